/* src/lfd_pkg.sv */
// Shared types and constants for the length-framed packet deframer.
// Used by lfd_in_stage, lfd_parser and length_framed_packet_deframer_top.
`default_nettype none

package lfd_pkg;

  localparam logic [7:0]  START_BYTE      = 8'h01;
  localparam logic [7:0]  END_BYTE        = 8'h04;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd1020;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_BODY   = 3'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_HEADER    = 3'd0,
    EV_PAYLOAD   = 3'd1,
    EV_DONE      = 3'd2,
    EV_BAD_START = 3'd3,
    EV_BAD_END   = 3'd4,
    EV_TOO_LONG  = 3'd5
  } event_t;

  // Registered input item handed from the input stage to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_item_t;

endpackage

`default_nettype wire

/* src/lfd_in_stage.sv */
// Input register stage: captures one received byte per accepted item.
// Depends on lfd_pkg for the in_item_t struct.
`default_nettype none

module lfd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_byte,
  input  wire logic              take,
  output lfd_pkg::in_item_t      item
);
  import lfd_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  // Refill in the same cycle the parser drains the held item.
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

`default_nettype wire

/* src/lfd_parser.sv */
// Frame state machine and result register of the deframer.
// Depends on lfd_pkg for phase/event codes and the in_item_t struct.
`default_nettype none

module lfd_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lfd_pkg::in_item_t item,
  output logic                   take,
  input  wire logic [15:0]       max_len,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_event_kind,
  output logic [7:0]             out_payload_data,
  output logic [15:0]            out_payload_index,
  output logic                   out_last_payload,
  output logic [15:0]            out_frame_length
);
  import lfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] alen_r, alen_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  event_t      kind;
  logic [7:0]  data;
  logic [15:0] idx;
  logic        last;
  logic [15:0] flen;

  logic [2:0]  kind_r;
  logic [7:0]  data_r;
  logic [15:0] idx_r;
  logic        last_r;
  logic [15:0] flen_r;

  logic [7:0]  b;

  assign b    = item.rx_byte;
  assign take = item.valid && (!out_valid_r || out_ready);

  always_comb begin
    phase_nxt = phase_r;
    alen_nxt  = alen_r;
    cnt_nxt   = cnt_r;
    kind      = EV_HEADER;
    data      = 8'd0;
    idx       = 16'd0;
    last      = 1'b0;
    flen      = 16'd0;
    unique case (phase_r)
      PH_LEN_HI: begin
        alen_nxt  = {b, 8'd0};
        flen      = {b, 8'd0};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        alen_nxt = {alen_r[15:8], b};
        flen     = {alen_r[15:8], b};
        cnt_nxt  = 16'd0;
        if ({alen_r[15:8], b} > max_len) begin
          kind      = EV_TOO_LONG;
          phase_nxt = PH_WAIT;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        flen = alen_r;
        if (cnt_r < alen_r) begin
          kind    = EV_PAYLOAD;
          data    = b;
          idx     = cnt_r;
          last    = ({1'b0, cnt_r} + 17'd1) == {1'b0, alen_r};
          cnt_nxt = cnt_r + 16'd1;
        end else begin
          kind      = (b == END_BYTE) ? EV_DONE : EV_BAD_END;
          phase_nxt = PH_WAIT;
        end
      end
      default: begin
        // Waiting, and any unused phase code: clear the frame state.
        alen_nxt = 16'd0;
        cnt_nxt  = 16'd0;
        if (b == START_BYTE) begin
          kind      = EV_HEADER;
          phase_nxt = PH_LEN_HI;
        end else begin
          kind      = EV_BAD_START;
          phase_nxt = PH_WAIT;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      alen_r      <= 16'd0;
      cnt_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      // Advance frame state only when an item moves into the result register.
      if (take) begin
        phase_r <= phase_nxt;
        alen_r  <= alen_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= kind;
      data_r <= data;
      idx_r  <= idx;
      last_r <= last;
      flen_r <= flen;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = kind_r;
  assign out_payload_data  = data_r;
  assign out_payload_index = idx_r;
  assign out_last_payload  = last_r;
  assign out_frame_length  = flen_r;

  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> kind_r == EV_PAYLOAD)
    else $error("last mark on a non-payload item");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == EV_PAYLOAD |-> idx_r < flen_r)
    else $error("payload index outside announced length");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> cnt_r <= alen_r)
    else $error("payload count ran past announced length");

  a_body_holds: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_BODY && cnt_r < alen_r |=> phase_r == PH_BODY)
    else $error("left payload phase before the last payload byte");

endmodule

`default_nettype wire

/* src/length_framed_packet_deframer_top.sv */
// Top level of the length-framed packet deframer: config register and stages.
// Depends on lfd_pkg, lfd_in_stage and lfd_parser.
// Path: an accepted byte passes through the input register, then the result register.
// Throughput: one byte per cycle while out_ready holds; the frame state advances with each byte taken.
// Reset (rst_n low, synchronous): waits for a start byte, limit back to 1020.
`default_nettype none

module length_framed_packet_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_kind,
  output logic [7:0]       out_payload_data,
  output logic [15:0]      out_payload_index,
  output logic             out_last_payload,
  output logic [15:0]      out_frame_length,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import lfd_pkg::*;

  logic [15:0] max_len_r;
  in_item_t    item;
  logic        take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  lfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .item       (item)
  );

  lfd_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .item              (item),
    .take              (take),
    .max_len           (max_len_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_payload_data  (out_payload_data),
    .out_payload_index (out_payload_index),
    .out_last_payload  (out_last_payload),
    .out_frame_length  (out_frame_length)
  );

endmodule

`default_nettype wire
